/* rtl/psu_pkg.sv */
// ----------------------------------------------------------------------------
// psu_pkg
// Shared constants for the Phong specular term pipeline.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int SHININESS  = 100;
  localparam int SHIN_BITS  = 8;
  localparam int MANT_BITS  = 15;
  localparam int SPEC_W     = 24;
  localparam int ISQRT_LAT  = 32;
  localparam int CDIV_STEPS = 31;
  localparam int CDIV_LAT   = CDIV_STEPS + 1;
  localparam int QSH        = 30 - FRAC_BITS;
  localparam int NUM_W      = SPEC_W + 31;
  localparam int QN_W       = NUM_W - QSH;

  localparam logic [30:0]       ONE_Q30  = 31'h4000_0000;
  localparam logic [SPEC_W-1:0] SPEC_MAX = '1;

  localparam logic [1:0] REG_CAM_X = 2'd0;
  localparam logic [1:0] REG_CAM_Y = 2'd1;
  localparam logic [1:0] REG_CAM_Z = 2'd2;
  localparam logic [1:0] REG_TOTAL = 2'd3;

  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    logic              kill;
    logic [SPEC_W-1:0] intensity;
  } side_t;

endpackage

/* rtl/phong_specular_term_unit.sv */
// ----------------------------------------------------------------------------
// phong_specular_term_unit
// Phong specular term in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  ports                          handshake
//  input    in_point/normal/lamp_*, start  accepted when start && !busy
//  result   out_specular, out_saturated    out_valid strobe, one cycle
//  config   psel/penable/pwrite/paddr/...  APB, pready always high
//
//  One item per cycle through 9 vector stages, 32 square root stages, 32
//  divider stages, 8 power stages and 27 for the product, the final
//  quotient and the result register.
//  busy stays low; the pipeline never stalls as results cannot be held off.
//  rst_n is synchronous and clears all valid bits and the configuration registers.
// ----------------------------------------------------------------------------
module phong_specular_term_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  psu_pkg::q16_t             in_point_x,
  input  psu_pkg::q16_t             in_point_y,
  input  psu_pkg::q16_t             in_point_z,
  input  psu_pkg::q16_t             in_normal_x,
  input  psu_pkg::q16_t             in_normal_y,
  input  psu_pkg::q16_t             in_normal_z,
  input  psu_pkg::q16_t             in_lamp_x,
  input  psu_pkg::q16_t             in_lamp_y,
  input  psu_pkg::q16_t             in_lamp_z,
  input  logic [psu_pkg::SPEC_W-1:0] in_lamp_intensity,
  output logic                      out_valid,
  output logic [psu_pkg::SPEC_W-1:0] out_specular,
  output logic                      out_saturated,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import psu_pkg::*;

  function automatic q16_t sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [63:0] shr_tz(input logic signed [63:0] x, input int k);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

  function automatic logic [4:0] norm_shift(input logic [31:0] m);
    logic [5:0] bl;
    bl = '0;
    for (int i = 0; i < 32; i++) if (m[i]) bl = 6'(i + 1);
    return (bl > 6'(MANT_BITS)) ? 5'(bl - 6'(MANT_BITS)) : 5'd0;
  endfunction

  function automatic logic [31:0] mag32(input q16_t x);
    return x[31] ? 32'(~x + 32'sd1) : 32'(x);
  endfunction

  function automatic logic [30:0] mulq(input logic [30:0] a, input logic [30:0] b);
    logic [62:0] t;
    t = 63'(a) * 63'(b) + 63'h2000_0000;
    return t[60:30];
  endfunction

  // configuration
  q16_t              cam_x_r, cam_y_r, cam_z_r;
  logic [SPEC_W-1:0] tl_r, tl_eff;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      tl_r    <= 24'h01_0000;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CAM_X: cam_x_r <= pwdata;
        REG_CAM_Y: cam_y_r <= pwdata;
        REG_CAM_Z: cam_z_r <= pwdata;
        REG_TOTAL: tl_r    <= pwdata[SPEC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CAM_X: prdata = cam_x_r;
      REG_CAM_Y: prdata = cam_y_r;
      REG_CAM_Z: prdata = cam_z_r;
      REG_TOTAL: prdata = 32'(tl_r);
      default:   prdata = '0;
    endcase
  end

  assign tl_eff = (tl_r == '0) ? SPEC_W'(1) : tl_r;
  assign busy   = 1'b0;

  q16_t pt[3], nv[3], lp[3], cam[3];
  assign pt  = '{in_point_x, in_point_y, in_point_z};
  assign nv  = '{in_normal_x, in_normal_y, in_normal_z};
  assign lp  = '{in_lamp_x, in_lamp_y, in_lamp_z};
  assign cam = '{cam_x_r, cam_y_r, cam_z_r};

  // vector stages
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic s6_vld_r, s7_vld_r, s8_vld_r, s9_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0; s2_vld_r <= 1'b0; s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0; s5_vld_r <= 1'b0; s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0; s8_vld_r <= 1'b0; s9_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
      s2_vld_r <= s1_vld_r; s3_vld_r <= s2_vld_r; s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r; s6_vld_r <= s5_vld_r; s7_vld_r <= s6_vld_r;
      s8_vld_r <= s7_vld_r; s9_vld_r <= s8_vld_r;
    end
  end

  q16_t               s1_l_r[3], s1_v_r[3], s1_n_r[3];
  logic signed [63:0] s2_p_r[3];
  q16_t               s2_l_r[3], s2_v_r[3], s2_n_r[3];
  q16_t               s3_d_r;
  q16_t               s3_l_r[3], s3_v_r[3], s3_n_r[3];
  logic signed [63:0] s4_nd_r[3];
  q16_t               s4_l_r[3], s4_v_r[3];
  q16_t               s5_r_r[3], s5_v_r[3];
  logic [31:0]        s6_rm_r[3], s6_vm_r[3], s6_ror_r, s6_vor_r;
  logic               s6_rs_r[3], s6_vs_r[3];
  logic signed [15:0] s7_r_r[3], s7_v_r[3];
  logic signed [33:0] s8_rv_r;
  logic [31:0]        s8_rr_r, s8_vv_r;
  logic [63:0]        s9_x_r;
  logic [31:0]        s9_rv_r;
  side_t              s1_sd_r, s2_sd_r, s3_sd_r, s4_sd_r, s5_sd_r;
  side_t              s6_sd_r, s7_sd_r, s8_sd_r, s9_sd_r;
  logic signed [63:0] s3_sum;
  logic [4:0]         s7_rsh, s7_vsh;
  logic [31:0]        s7_rt[3], s7_vt[3];

  assign s3_sum = shr_tz(s2_p_r[0], FRAC_BITS) + shr_tz(s2_p_r[1], FRAC_BITS)
                + shr_tz(s2_p_r[2], FRAC_BITS);
  assign s7_rsh = norm_shift(s6_ror_r);
  assign s7_vsh = norm_shift(s6_vor_r);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s7_rt[k] = s6_rm_r[k] >> s7_rsh;
      s7_vt[k] = s6_vm_r[k] >> s7_vsh;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      s1_l_r[k]  <= sat32(64'(pt[k]) - 64'(lp[k]));
      s1_v_r[k]  <= sat32(64'(pt[k]) - 64'(cam[k]));
      s1_n_r[k]  <= nv[k];
      s2_p_r[k]  <= 64'(s1_l_r[k]) * 64'(s1_n_r[k]);
      s2_l_r[k]  <= s1_l_r[k];
      s2_v_r[k]  <= s1_v_r[k];
      s2_n_r[k]  <= s1_n_r[k];
      s3_l_r[k]  <= s2_l_r[k];
      s3_v_r[k]  <= s2_v_r[k];
      s3_n_r[k]  <= s2_n_r[k];
      s4_nd_r[k] <= 64'(s3_n_r[k]) * 64'(s3_d_r);
      s4_l_r[k]  <= s3_l_r[k];
      s4_v_r[k]  <= s3_v_r[k];
      s5_r_r[k]  <= sat32(shr_tz(s4_nd_r[k], FRAC_BITS - 1) - 64'(s4_l_r[k]));
      s5_v_r[k]  <= s4_v_r[k];
      s6_rm_r[k] <= mag32(s5_r_r[k]);
      s6_vm_r[k] <= mag32(s5_v_r[k]);
      s6_rs_r[k] <= s5_r_r[k][31];
      s6_vs_r[k] <= s5_v_r[k][31];
      s7_r_r[k]  <= s6_rs_r[k] ? -$signed({1'b0, s7_rt[k][14:0]})
                               :  $signed({1'b0, s7_rt[k][14:0]});
      s7_v_r[k]  <= s6_vs_r[k] ? -$signed({1'b0, s7_vt[k][14:0]})
                               :  $signed({1'b0, s7_vt[k][14:0]});
    end
    s1_sd_r.kill      <= 1'b0;
    s1_sd_r.intensity <= in_lamp_intensity;
    s2_sd_r  <= s1_sd_r;
    s3_d_r   <= sat32(s3_sum);
    s3_sd_r  <= '{kill: s2_sd_r.kill || s3_sum[63], intensity: s2_sd_r.intensity};
    s4_sd_r  <= s3_sd_r;
    s5_sd_r  <= s4_sd_r;
    s6_ror_r <= mag32(s5_r_r[0]) | mag32(s5_r_r[1]) | mag32(s5_r_r[2]);
    s6_vor_r <= mag32(s5_v_r[0]) | mag32(s5_v_r[1]) | mag32(s5_v_r[2]);
    s6_sd_r  <= s5_sd_r;
    s7_sd_r  <= s6_sd_r;
    s8_rv_r  <= 34'(s7_r_r[0]) * 34'(s7_v_r[0]) + 34'(s7_r_r[1]) * 34'(s7_v_r[1])
              + 34'(s7_r_r[2]) * 34'(s7_v_r[2]);
    s8_rr_r  <= 32'(34'(s7_r_r[0]) * 34'(s7_r_r[0]) + 34'(s7_r_r[1]) * 34'(s7_r_r[1])
              + 34'(s7_r_r[2]) * 34'(s7_r_r[2]));
    s8_vv_r  <= 32'(34'(s7_v_r[0]) * 34'(s7_v_r[0]) + 34'(s7_v_r[1]) * 34'(s7_v_r[1])
              + 34'(s7_v_r[2]) * 34'(s7_v_r[2]));
    s8_sd_r  <= s7_sd_r;
    s9_x_r   <= 64'(s8_rr_r) * 64'(s8_vv_r);
    s9_rv_r  <= s8_rv_r[31:0];
    s9_sd_r  <= '{kill: s8_sd_r.kill || (s8_rv_r <= 34'sd0) || (s8_rr_r == '0)
                        || (s8_vv_r == '0),
                  intensity: s8_sd_r.intensity};
  end

  // square root, with matching side lines
  logic        isq_vld;
  logic [31:0] isq_root;
  side_t       isd_r [ISQRT_LAT];
  logic [31:0] irv_r [ISQRT_LAT];

  psu_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s9_vld_r),
    .in_x     (s9_x_r),
    .out_vld  (isq_vld),
    .out_root (isq_root)
  );

  always_ff @(posedge clk) begin
    isd_r[0] <= s9_sd_r;
    irv_r[0] <= s9_rv_r;
    for (int k = 1; k < ISQRT_LAT; k++) begin
      isd_r[k] <= isd_r[k-1];
      irv_r[k] <= irv_r[k-1];
    end
  end

  // cosine divider
  logic        cd_vld;
  logic [30:0] cd_c, c_cl;
  side_t       csd_r [CDIV_LAT];

  psu_cdiv u_cdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (isq_vld),
    .in_rv   (irv_r[ISQRT_LAT-1]),
    .in_len  (isq_root),
    .out_vld (cd_vld),
    .out_c   (cd_c)
  );

  always_ff @(posedge clk) begin
    csd_r[0] <= '{kill: isd_r[ISQRT_LAT-1].kill || (isq_root == '0),
                  intensity: isd_r[ISQRT_LAT-1].intensity};
    for (int k = 1; k < CDIV_LAT; k++) csd_r[k] <= csd_r[k-1];
  end

  assign c_cl = (cd_c > ONE_Q30) ? ONE_Q30 : cd_c;

  // power by square and multiply
  logic        pv_r  [SHIN_BITS];
  logic [30:0] pw_r  [SHIN_BITS];
  logic [30:0] pc_r  [SHIN_BITS];
  side_t       psd_r [SHIN_BITS];

  genvar i;
  generate
    for (i = 0; i < SHIN_BITS; i++) begin : g_pow
      logic        vp;
      logic [30:0] wp, cp, wn;
      side_t       sp;
      if (i == 0) begin : g_first
        assign vp = cd_vld;
        assign wp = ONE_Q30;
        assign cp = c_cl;
        assign sp = csd_r[CDIV_LAT-1];
      end else begin : g_next
        assign vp = pv_r[i-1];
        assign wp = pw_r[i-1];
        assign cp = pc_r[i-1];
        assign sp = psd_r[i-1];
      end
      if (((SHININESS >> i) & 1) == 1) begin : g_mul
        assign wn = mulq(wp, cp);
      end else begin : g_keep
        assign wn = wp;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          pv_r[i] <= 1'b0;
        end else begin
          pv_r[i] <= vp;
        end
      end

      always_ff @(posedge clk) begin
        pw_r[i]  <= wn;
        pc_r[i]  <= mulq(cp, cp);
        psd_r[i] <= sp;
      end
    end
  endgenerate

  // intensity * pow, then quotient by total light
  logic             nm_vld_r, nm_kill_r;
  logic [NUM_W-1:0] nm_r;
  logic [QN_W-1:0]  nq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_vld_r <= 1'b0;
    end else begin
      nm_vld_r <= pv_r[SHIN_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    nm_r      <= NUM_W'(psd_r[SHIN_BITS-1].intensity) * NUM_W'(pw_r[SHIN_BITS-1]);
    nm_kill_r <= psd_r[SHIN_BITS-1].kill;
  end

  assign nq = nm_r[NUM_W-1:QSH];

  logic              qv_r   [SPEC_W+1];
  logic              qk_r   [SPEC_W+1];
  logic              qs_r   [SPEC_W+1];
  logic [SPEC_W-1:0] qrem_r [SPEC_W+1];
  logic [SPEC_W-1:0] qlow_r [SPEC_W+1];
  logic [SPEC_W-1:0] qq_r   [SPEC_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r[0] <= 1'b0;
    end else begin
      qv_r[0] <= nm_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    qk_r[0]   <= nm_kill_r;
    qs_r[0]   <= (nq >> SPEC_W) >= QN_W'(tl_eff);
    qrem_r[0] <= SPEC_W'(nq >> SPEC_W);
    qlow_r[0] <= nq[SPEC_W-1:0];
    qq_r[0]   <= '0;
  end

  generate
    for (i = 1; i <= SPEC_W; i++) begin : g_quo
      logic [SPEC_W:0] sh;
      logic            ge;
      assign sh = {qrem_r[i-1], qlow_r[i-1][SPEC_W-1]};
      assign ge = sh >= {1'b0, tl_eff};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          qv_r[i] <= 1'b0;
        end else begin
          qv_r[i] <= qv_r[i-1];
        end
      end

      always_ff @(posedge clk) begin
        qk_r[i]   <= qk_r[i-1];
        qs_r[i]   <= qs_r[i-1];
        qrem_r[i] <= ge ? SPEC_W'(sh - {1'b0, tl_eff}) : sh[SPEC_W-1:0];
        qlow_r[i] <= qlow_r[i-1] << 1;
        qq_r[i]   <= {qq_r[i-1][SPEC_W-2:0], ge};
      end
    end
  endgenerate

  // result register
  logic              out_vld_r, out_sat_r;
  logic [SPEC_W-1:0] out_spec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= qv_r[SPEC_W];
    end
  end

  always_ff @(posedge clk) begin
    out_spec_r <= qk_r[SPEC_W] ? '0 : (qs_r[SPEC_W] ? SPEC_MAX : qq_r[SPEC_W]);
    out_sat_r  <= !qk_r[SPEC_W] && qs_r[SPEC_W];
  end

  assign out_valid     = out_vld_r;
  assign out_specular  = out_spec_r;
  assign out_saturated = out_sat_r;

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_specular == SPEC_MAX)
    else $error("saturated item without full-scale value");

  a_pow_range: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r[SHIN_BITS-1] |-> pw_r[SHIN_BITS-1] <= ONE_Q30)
    else $error("power term above one");

  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result strobe straight after reset");

endmodule

/* rtl/psu_isqrt.sv */
// ----------------------------------------------------------------------------
// psu_isqrt
// Pipelined floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module psu_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [63:0] in_x,
  output logic        out_vld,
  output logic [31:0] out_root
);
  import psu_pkg::*;

  logic        vld_r [ISQRT_LAT];
  logic [63:0] x_r   [ISQRT_LAT];
  logic [63:0] res_r [ISQRT_LAT];

  genvar i;
  generate
    for (i = 0; i < ISQRT_LAT; i++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
      logic        vp;
      logic [63:0] xp, rp, trial;
      if (i == 0) begin : g_first
        assign vp = in_vld;
        assign xp = in_x;
        assign rp = '0;
      end else begin : g_next
        assign vp = vld_r[i-1];
        assign xp = x_r[i-1];
        assign rp = res_r[i-1];
      end
      assign trial = rp + BIT;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else begin
          vld_r[i] <= vp;
        end
      end

      always_ff @(posedge clk) begin
        if (xp >= trial) begin
          x_r[i]   <= xp - trial;
          res_r[i] <= (rp >> 1) + BIT;
        end else begin
          x_r[i]   <= xp;
          res_r[i] <= rp >> 1;
        end
      end
    end
  endgenerate

  assign out_vld  = vld_r[ISQRT_LAT-1];
  assign out_root = res_r[ISQRT_LAT-1][31:0];

endmodule

/* rtl/psu_cdiv.sv */
// ----------------------------------------------------------------------------
// psu_cdiv
// Pipelined restoring divider for the Q1.30 cosine, one quotient bit a stage.
// ----------------------------------------------------------------------------
module psu_cdiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [31:0] in_rv,
  input  logic [31:0] in_len,
  output logic        out_vld,
  output logic [30:0] out_c
);
  import psu_pkg::*;

  logic        vld_r [CDIV_LAT];
  logic [31:0] rem_r [CDIV_LAT];
  logic [31:0] d_r   [CDIV_LAT];
  logic [30:0] q_r   [CDIV_LAT];
  logic        nb_r;

  // rv << 30 over len; rv never exceeds len, so rv >> 1 is a valid start
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= {1'b0, in_rv[31:1]};
    d_r[0]   <= in_len;
    q_r[0]   <= '0;
    nb_r     <= in_rv[0];
  end

  genvar i;
  generate
    for (i = 1; i <= CDIV_STEPS; i++) begin : g_step
      logic        nbit;
      logic [32:0] sh;
      logic        ge;
      if (i == 1) begin : g_first
        assign nbit = nb_r;
      end else begin : g_next
        assign nbit = 1'b0;
      end
      assign sh = {rem_r[i-1], nbit};
      assign ge = sh >= {1'b0, d_r[i-1]};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else begin
          vld_r[i] <= vld_r[i-1];
        end
      end

      always_ff @(posedge clk) begin
        rem_r[i] <= ge ? 32'(sh - {1'b0, d_r[i-1]}) : sh[31:0];
        d_r[i]   <= d_r[i-1];
        q_r[i]   <= {q_r[i-1][29:0], ge};
      end
    end
  endgenerate

  assign out_vld = vld_r[CDIV_LAT-1];
  assign out_c   = q_r[CDIV_LAT-1];

endmodule
